/* design/rhc_pkg.sv */
// Package for the run-hour counter unit: item codes, field widths and reset values.
package rhc_pkg;

    // Field widths of the input item
    localparam int ELAPSED_W = 24;
    localparam int INDEX_W   = 3;
    localparam int FRAC_W    = 16;

    // Field widths of the result item
    localparam int COUNT_W      = 32;
    localparam int OUT_COUNTERS = 5;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 24;
    localparam int THRESH_W   = 16;

    // Register reset values
    localparam logic [THRESH_W-1:0]  THRESH_RESET   = 16'd1800;
    localparam logic [ELAPSED_W-1:0] MAX_STEP_RESET = 24'd327680;

    // Packed stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 200;

    // Item kinds, carried in s_tuser
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_SAVE  = 2'd2
    } mode_t;

    // Result status, carried in m_tuser
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_INDEX = 2'd1,
        STATUS_RUNNING   = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD = 1'd0,
        REG_MAX_STEP  = 1'd1
    } cfg_reg_t;

endpackage

/* design/run_hour_counters_with_save_policy_unit.sv */
// Run-hour counter bank with snapshot save policy, single-pass streaming unit.
// Two register stages: an accepted item is held in the input stage, and its result
// is registered in the result stage and shown on m_*. Throughput: one item per cycle
// while m_tready does not hold the result stage; the counter update for each item is one combinational pass.
// Reset (aresetn low, synchronous): counters, snapshot, fraction and save count
// clear, both stages empty, registers return to 1800 s and 5.0 s.
module run_hour_counters_with_save_policy_unit
    import rhc_pkg::*;
#(
    parameter int NUM_COUNTERS = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [23:0] elapsed_time, [24] engine_stopped, [27:25] counter_index, [31:28] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [1:0]            s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] count_front_tire, [63:32] count_rear_tire, [95:64] count_cylinder,
    // [127:96] count_piston, [159:128] count_engine, [160] saved_now,
    // [192:161] save_total, [199:193] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [1:0]            m_tuser
);

    localparam int IDX_CMP_W = INDEX_W + 1;

    // configuration registers
    logic [THRESH_W-1:0]  thresh_reg;
    logic [ELAPSED_W-1:0] max_step_reg;

    // input stage
    logic                 in_valid_reg;
    logic [1:0]           in_mode_reg;
    logic [ELAPSED_W-1:0] in_elapsed_reg;
    logic                 in_stopped_reg;
    logic [INDEX_W-1:0]   in_index_reg;

    // stored state
    logic [COUNT_W-1:0] run_reg  [NUM_COUNTERS];
    logic [COUNT_W-1:0] snap_reg [NUM_COUNTERS];
    logic [FRAC_W-1:0]  frac_reg;
    logic [COUNT_W-1:0] save_count_reg;

    logic [COUNT_W-1:0] run_next  [NUM_COUNTERS];
    logic [COUNT_W-1:0] snap_next [NUM_COUNTERS];
    logic [FRAC_W-1:0]  frac_next;
    logic [COUNT_W-1:0] save_count_next;

    // result stage
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]           m_tuser_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    status_t              status_next;
    logic                 saved_next;

    // handshake
    logic out_free;
    logic advance;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= THRESH_RESET;
            max_step_reg <= MAX_STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_THRESHOLD: thresh_reg   <= cfg_wdata[THRESH_W-1:0];
                REG_MAX_STEP:  max_step_reg <= cfg_wdata[ELAPSED_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg    <= s_tuser;
            in_elapsed_reg <= s_tdata[ELAPSED_W-1:0];
            in_stopped_reg <= s_tdata[ELAPSED_W];
            in_index_reg   <= s_tdata[ELAPSED_W+INDEX_W:ELAPSED_W+1];
        end
    end

    // item processing: tick, counter clear or forced save
    always_comb begin
        logic [ELAPSED_W-1:0] step;
        logic [ELAPSED_W:0]   total;
        logic [ELAPSED_W-FRAC_W:0] whole;
        logic                 check;
        logic                 force_save;
        logic                 need;
        logic [COUNT_W-1:0]   diff;

        step       = (in_elapsed_reg < max_step_reg) ? in_elapsed_reg : max_step_reg;
        total      = {{(ELAPSED_W-FRAC_W+1){1'b0}}, frac_reg} + {1'b0, step};
        whole      = total[ELAPSED_W:FRAC_W];
        check      = 1'b0;
        force_save = 1'b0;
        status_next = STATUS_OK;
        frac_next  = frac_reg;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            run_next[i] = run_reg[i];
        end

        case (in_mode_reg)
            MODE_TICK: begin
                if (!in_stopped_reg) begin
                    frac_next = total[FRAC_W-1:0];
                    for (int i = 0; i < NUM_COUNTERS; i++) begin
                        run_next[i] = run_reg[i] + COUNT_W'(whole);
                    end
                end else begin
                    check = 1'b1;
                end
            end
            MODE_CLEAR: begin
                if ({1'b0, in_index_reg} >= IDX_CMP_W'(NUM_COUNTERS)) begin
                    status_next = STATUS_BAD_INDEX;
                end else if (!in_stopped_reg) begin
                    status_next = STATUS_RUNNING;
                end else begin
                    for (int i = 0; i < NUM_COUNTERS; i++) begin
                        if (INDEX_W'(i) == in_index_reg) begin
                            run_next[i] = '0;
                        end
                    end
                    check      = 1'b1;
                    force_save = 1'b1;
                end
            end
            MODE_SAVE: begin
                check      = 1'b1;
                force_save = 1'b1;
            end
            default: ;
        endcase

        // save rule: a counter behind its snapshot, or drifted by the threshold
        need = force_save;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            diff = run_next[i] - snap_reg[i];
            if (run_next[i] < snap_reg[i] || diff >= COUNT_W'(thresh_reg)) begin
                need = 1'b1;
            end
        end
        saved_next = check && need;

        save_count_next = save_count_reg + (saved_next ? COUNT_W'(1) : COUNT_W'(0));
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            snap_next[i] = saved_next ? run_next[i] : snap_reg[i];
        end
    end

    // result packing; counters that do not exist read zero
    genvar g;
    generate
        for (g = 0; g < OUT_COUNTERS; g++) begin : g_out
            if (g < NUM_COUNTERS) begin : g_have
                assign m_tdata_next[g*COUNT_W +: COUNT_W] = run_next[g];
            end else begin : g_none
                assign m_tdata_next[g*COUNT_W +: COUNT_W] = '0;
            end
        end
    endgenerate

    assign m_tdata_next[OUT_COUNTERS*COUNT_W] = saved_next;
    assign m_tdata_next[OUT_COUNTERS*COUNT_W+1 +: COUNT_W] = save_count_next;
    assign m_tdata_next[M_TDATA_W-1:OUT_COUNTERS*COUNT_W+1+COUNT_W] = '0;

    // state update, one item per advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                run_reg[i]  <= '0;
                snap_reg[i] <= '0;
            end
            frac_reg       <= '0;
            save_count_reg <= '0;
        end else if (advance) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                run_reg[i]  <= run_next[i];
                snap_reg[i] <= snap_next[i];
            end
            frac_reg       <= frac_next;
            save_count_reg <= save_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= status_next;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the run-hour counter unit: stream driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top;
    import rhc_pkg::*;

    localparam int N_CTR = 5;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AT  = 900;   // results seen before the long receiver hold
    localparam int HOLD_LEN = 400;   // cycles of the long hold
    localparam int PHASE_ITEMS = 200;

    // one input item
    typedef struct packed {
        logic [1:0]           mode;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 stopped;
        logic [INDEX_W-1:0]   idx;
    } stim_item_t;

    // one result item
    typedef struct packed {
        logic [OUT_COUNTERS-1:0][COUNT_W-1:0] cnt;
        logic                                 saved;
        logic [COUNT_W-1:0]                   total;
        status_t                              status;
    } hour_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;

    run_hour_counters_with_save_policy_unit #(.NUM_COUNTERS(N_CTR)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state and its copy of the registers
    logic [COUNT_W-1:0]   run_ctr  [N_CTR];
    logic [COUNT_W-1:0]   snap_ctr [N_CTR];
    logic [FRAC_W-1:0]    frac_acc;
    logic [COUNT_W-1:0]   saves_done;
    logic [THRESH_W-1:0]  thr_reg;
    logic [ELAPSED_W-1:0] max_step_reg;

    stim_item_t   pending_items[$];
    hour_result_t expected_results[$];
    stim_item_t   on_bus;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  err_count = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  rx_seen = 0;
    int unsigned  stall_left = 0;
    bit           stall_done = 1'b0;

    // snapshot refresh: forced, or a counter fell back or drifted by the threshold
    function automatic logic apply_save_rule(logic forced);
        logic need;
        need = forced;
        for (int i = 0; i < N_CTR; i++) begin
            if (run_ctr[i] < snap_ctr[i] ||
                COUNT_W'(run_ctr[i] - snap_ctr[i]) >= {16'd0, thr_reg})
                need = 1'b1;
        end
        if (need) begin
            for (int i = 0; i < N_CTR; i++) snap_ctr[i] = run_ctr[i];
            saves_done = saves_done + 1;
        end
        return need;
    endfunction

    // advance the counter bank by one item and give the result it causes
    function automatic hour_result_t hour_bank_step(stim_item_t it);
        hour_result_t r;
        logic [ELAPSED_W-1:0] step;
        logic [ELAPSED_W:0]   sum;
        r = '0;
        r.status = STATUS_OK;
        case (it.mode)
            MODE_TICK: begin
                if (!it.stopped) begin
                    step = (it.elapsed < max_step_reg) ? it.elapsed : max_step_reg;
                    sum = {9'd0, frac_acc} + {1'b0, step};
                    frac_acc = sum[FRAC_W-1:0];
                    for (int i = 0; i < N_CTR; i++)
                        run_ctr[i] = run_ctr[i] + COUNT_W'(sum >> FRAC_W);
                end else begin
                    r.saved = apply_save_rule(1'b0);
                end
            end
            MODE_CLEAR: begin
                // index is checked before the engine state
                if (it.idx >= N_CTR) begin
                    r.status = STATUS_BAD_INDEX;
                end else if (!it.stopped) begin
                    r.status = STATUS_RUNNING;
                end else begin
                    run_ctr[it.idx] = '0;
                    r.saved = apply_save_rule(1'b1);
                end
            end
            MODE_SAVE: r.saved = apply_save_rule(1'b1);
            default: ;
        endcase
        for (int i = 0; i < OUT_COUNTERS; i++)
            r.cnt[i] = (i < N_CTR) ? run_ctr[i] : '0;
        r.total = saves_done;
        return r;
    endfunction

    function automatic stim_item_t mk(logic [1:0] m, logic [ELAPSED_W-1:0] e, logic st,
                                      logic [INDEX_W-1:0] ix);
        stim_item_t it;
        it.mode = m; it.elapsed = e; it.stopped = st; it.idx = ix;
        return it;
    endfunction

    // mostly running ticks with stopped checks, some clears, saves and noise
    function automatic stim_item_t rand_item();
        stim_item_t it;
        int unsigned pick;
        int unsigned near;
        pick = $urandom_range(99);
        it.idx = INDEX_W'($urandom_range(7));
        it.stopped = 1'($urandom_range(1));
        if (pick < 50) begin
            it.mode = MODE_TICK; it.stopped = 1'b0;
        end else if (pick < 72) begin
            it.mode = MODE_TICK; it.stopped = 1'b1;
        end else if (pick < 84) begin
            it.mode = MODE_CLEAR; it.stopped = ($urandom_range(3) != 0);
        end else if (pick < 95) begin
            it.mode = MODE_SAVE;
        end else begin
            it.mode = MODE_UNUSED;
        end
        case ($urandom_range(3))
            0: it.elapsed = ELAPSED_W'($urandom);
            1: it.elapsed = ELAPSED_W'($urandom_range(0, 24'h3FFFF));
            2: begin
                near = max_step_reg + $urandom_range(0, 4);
                it.elapsed = (near < 2) ? ELAPSED_W'(near) : ELAPSED_W'(near - 2);
            end
            default: it.elapsed = $urandom_range(1) ? '1 : '0;
        endcase
        return it;
    endfunction

    // sender: offers queued items, predicts each one at acceptance
    always @(posedge aclk) begin : item_driver
        bit took;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            took = s_tvalid && s_tready;
            if (took) expected_results.push_back(hour_bank_step(on_bus));
            if (s_tvalid && !took) begin
                // hold the item until it is taken
            end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                on_bus = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {4'd0, on_bus.idx, on_bus.stopped, on_bus.elapsed};
                s_tuser <= on_bus.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold
    always @(posedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) rx_seen++;
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!stall_done && rx_seen == HOLD_AT) begin
                stall_left = HOLD_LEN;
                stall_done = 1'b1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // monitor: each result against the oldest expectation
    always @(posedge aclk) begin : result_check
        hour_result_t got;
        hour_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            for (int i = 0; i < OUT_COUNTERS; i++) got.cnt[i] = m_tdata[COUNT_W*i +: COUNT_W];
            got.saved  = m_tdata[COUNT_W*OUT_COUNTERS];
            got.total  = m_tdata[COUNT_W*OUT_COUNTERS+1 +: COUNT_W];
            got.status = status_t'(m_tuser);
            if (expected_results.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result item: %h", m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got.cnt !== want.cnt || got.saved !== want.saved ||
                    got.total !== want.total || got.status !== want.status) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: cnt exp %h got %h, saved exp %b got %b, ",
                                  "total exp %0d got %0d, status exp %0d got %0d"},
                                 want.cnt, got.cnt, want.saved, got.saved,
                                 want.total, got.total, want.status, got.status);
                end
            end
        end
    end

    // watchdog: cycles with work outstanding but no handshake on either side
    always @(posedge aclk) begin : watchdog
        if (aresetn && (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (r)
            REG_THRESHOLD: thr_reg = v[THRESH_W-1:0];
            default:       max_step_reg = v;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] mstep,
                             int unsigned snd, int unsigned rcv);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MAX_STEP, mstep);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(rand_item());
        wait_drained();
    endtask

    initial begin : sequencer
        for (int i = 0; i < N_CTR; i++) begin
            run_ctr[i] = '0;
            snap_ctr[i] = '0;
        end
        frac_acc = '0;
        saves_done = '0;
        thr_reg = THRESH_RESET;
        max_step_reg = MAX_STEP_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items on the reset settings
        send_idle_pct = 28;
        recv_idle_pct = 71;
        pending_items.push_back(mk(MODE_TICK, 24'd0, 1'b0, 3'd0));
        pending_items.push_back(mk(MODE_TICK, 24'hFFFFFF, 1'b0, 3'd7));   // clamped
        pending_items.push_back(mk(MODE_TICK, 24'h008000, 1'b0, 3'd0));   // half second
        pending_items.push_back(mk(MODE_TICK, 24'h008000, 1'b0, 3'd0));   // carry out
        pending_items.push_back(mk(MODE_TICK, 24'h04FFFF, 1'b0, 3'd0));
        pending_items.push_back(mk(MODE_TICK, 24'h050001, 1'b0, 3'd0));
        pending_items.push_back(mk(MODE_TICK, 24'hFFFFFF, 1'b1, 3'd7));   // stopped, no drift
        pending_items.push_back(mk(MODE_CLEAR, 24'd0, 1'b1, 3'd0));
        pending_items.push_back(mk(MODE_CLEAR, 24'd0, 1'b1, 3'd7));       // bad index
        pending_items.push_back(mk(MODE_CLEAR, 24'd0, 1'b0, 3'd5));       // bad index beats running
        pending_items.push_back(mk(MODE_CLEAR, 24'hFFFFFF, 1'b0, 3'd2));  // refused while running
        pending_items.push_back(mk(MODE_SAVE, 24'd0, 1'b0, 3'd0));
        pending_items.push_back(mk(MODE_SAVE, 24'hFFFFFF, 1'b1, 3'd7));
        pending_items.push_back(mk(MODE_UNUSED, 24'hFFFFFF, 1'b1, 3'd1)); // ignored mode
        pending_items.push_back(mk(MODE_UNUSED, 24'd0, 1'b0, 3'd4));
        pending_items.push_back(mk(MODE_TICK, 24'h03C000, 1'b0, 3'd3));
        pending_items.push_back(mk(MODE_CLEAR, 24'd0, 1'b1, 3'd4));
        pending_items.push_back(mk(MODE_CLEAR, 24'd0, 1'b1, 3'd1));
        pending_items.push_back(mk(MODE_CLEAR, 24'd0, 1'b1, 3'd3));
        pending_items.push_back(mk(MODE_CLEAR, 24'd0, 1'b1, 3'd6));
        pending_items.push_back(mk(MODE_TICK, 24'd1, 1'b0, 3'd0));
        pending_items.push_back(mk(MODE_TICK, 24'd0, 1'b1, 3'd0));
        wait_drained();

        // random phases over a spread of settings
        run_phase(24'd1, 24'hFFFFFF, 28, 71);
        run_phase(24'd65535, 24'd0, 28, 71);
        run_phase(24'd0, 24'($urandom), 71, 28);        // every stopped tick saves
        run_phase(24'($urandom_range(1, 300)), 24'($urandom), 71, 28);
        run_phase(24'($urandom_range(1, 50)), 24'd327680, 0, 0);
        run_phase(24'd2000, 24'hFFFFFF, 0, 0);

        repeat (10) @(posedge aclk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/rhc_pkg.sv
design/run_hour_counters_with_save_policy_unit.sv
tb/sv/tb_top.sv
